// ===== hdl/string_key_hash_set_probing_macros.svh =====
// ----------------------------------------------------------------------------
// String key hash set: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef STRING_KEY_HASH_SET_PROBING_MACROS_SVH
`define STRING_KEY_HASH_SET_PROBING_MACROS_SVH

// same-cycle implication
`define SKHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/skhs_pkg.sv =====
// ----------------------------------------------------------------------------
// String key hash set: package
// Table geometry, hash and probe constants, command and status codes.
// ----------------------------------------------------------------------------
package skhs_pkg;

  localparam int SLOTS             = 101;
  localparam int SLOT_W            = 7;
  localparam int PROBE_STEPS       = 19;
  localparam int PROBE_W           = $clog2(PROBE_STEPS + 1);
  localparam int HASH_MUL          = 19;
  localparam int PROBE_LIN         = 23;
  localparam int DEF_MAX_KEY_CHARS = 16;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_DEL = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED         = 3'd0,
    ST_DUPLICATE     = 3'd1,
    ST_NO_PROBE_SLOT = 3'd2,
    ST_TABLE_FULL    = 3'd3,
    ST_REMOVED       = 3'd4,
    ST_NOT_FOUND     = 3'd5,
    ST_TOO_LONG      = 3'd6
  } status_t;

endpackage

// ===== hdl/skhs_key_if.sv =====
// ----------------------------------------------------------------------------
// String key hash set: key byte channel
// One beat carries one key character, its command and the last-byte mark.
// ----------------------------------------------------------------------------
interface skhs_key_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] key_byte;
  logic       last_byte;

  modport source(output valid, func, key_byte, last_byte, input ready);
  modport sink(input valid, func, key_byte, last_byte, output ready);
endinterface

// ===== hdl/skhs_res_if.sv =====
// ----------------------------------------------------------------------------
// String key hash set: result channel
// One beat per finished command: status, slot and occupancy.
// ----------------------------------------------------------------------------
interface skhs_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] slot_index;
  logic [6:0] entries_held;

  modport source(output valid, status, slot_index, entries_held, input ready);
  modport sink(input valid, status, slot_index, entries_held, output ready);
endinterface

// ===== hdl/string_key_hash_set_probing.sv =====
// ----------------------------------------------------------------------------
// String key hash set with quadratic probing
// 101-slot set of byte-string keys: add and delete, keys streamed a byte
// per beat, hash reduced mod 101 by a reciprocal multiply, probes walked by
// a small sequencer that compares one key byte per cycle.
// ----------------------------------------------------------------------------
//  channel   dir  beat content
//  key_in    in   func, key_byte, last_byte (one key character)
//  res_out   out  status, slot_index, entries_held (one per last byte)
//
//  A last byte starts a command: the hash is reduced, up to 20 probes
//  test slots (empty, or length check then byte compare), probing stops
//  at a hit, only a successful add copies the key in, and the result is
//  loaded. An overlong key goes straight to its result. Hash reduction is
//  a reciprocal multiply for the quotient, then a multiply-subtract.
//  key_in.ready is high only while the sequencer is idle; a result waits in
//  the output register and does not hold off byte beats, only the next
//  command's completion. rst clears the used bits, count and key state.
// ----------------------------------------------------------------------------
module string_key_hash_set_probing
  import skhs_pkg::*;
#(
  parameter int MAX_KEY_CHARS = DEF_MAX_KEY_CHARS
) (
  input  logic              clk,
  input  logic              rst,
  skhs_key_if.sink          key_in,
  skhs_res_if.source        res_out
);

`include "string_key_hash_set_probing_macros.svh"

  localparam int LW    = $clog2(MAX_KEY_CHARS + 1);              // key length
  localparam int IW    = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
  localparam int SW    = $clog2(HASH_MUL * 255 * MAX_KEY_CHARS * (MAX_KEY_CHARS + 1) / 2 + 1);
  localparam int RS    = SW + SLOT_W;                            // reciprocal shift
  localparam longint RM = ((longint'(1) << RS) + longint'(SLOTS - 1)) / longint'(SLOTS);
  localparam int MW    = SW + 1;                                 // reciprocal width
  localparam int QW    = SW - SLOT_W + 1;                        // quotient width
  localparam int DEPTH = SLOTS * MAX_KEY_CHARS;
  localparam int KAW   = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_PROBE, S_LEN, S_CMP, S_DECIDE, S_COPY, S_FIN
  } state_t;

  state_t               state;
  logic [LW-1:0]        inc_len;
  logic                 ovl;
  logic [SW-1:0]        sum;
  logic                 func_q;
  logic [SW-1:0]        rem;
  logic                 mod_ph;
  logic [QW-1:0]        quo;
  logic [SLOT_W-1:0]    addr;
  logic [PROBE_W-1:0]   i;
  logic [IW-1:0]        j;
  logic [SLOTS-1:0]     used;
  logic [SLOT_W-1:0]    cnt;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_slot;
  logic [KAW-1:0]       pbase;
  logic [KAW-1:0]       fbase;
  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic                 rv;
  status_t              ro_status;
  logic [SLOT_W-1:0]    ro_slot;
  logic [SLOT_W-1:0]    ro_held;

  // memories
  logic [7:0]           inc_mem [MAX_KEY_CHARS];
  logic [7:0]           key_mem [DEPTH];
  logic [LW-1:0]        len_mem [SLOTS];
  logic [7:0]           inc_q;
  logic [7:0]           key_q;
  logic [LW-1:0]        len_q;

  logic                 accept;
  logic                 room;
  logic                 ovl_now;
  logic [LW-1:0]        len_new;
  logic [SW-1:0]        sum_next;
  logic [SW+MW-1:0]     prod;
  logic [SW-1:0]        home_full;
  logic [SLOT_W:0]      step_sum;
  logic [SLOT_W-1:0]    addr_next;
  logic                 probe_end;
  logic [KAW-1:0]       base;
  logic                 table_full;
  logic                 add_ok;
  logic [IW-1:0]        inc_raddr;
  logic                 out_free;
  logic                 last_idx;

  assign accept  = key_in.valid && key_in.ready;
  assign room    = inc_len < LW'(MAX_KEY_CHARS);
  assign ovl_now = ovl || !room;
  assign len_new = inc_len + LW'(1);
  assign sum_next = sum + SW'(HASH_MUL) * SW'(key_in.key_byte) * SW'(len_new);

  // mod-101: exact quotient by reciprocal multiply, remainder next cycle
  assign prod      = (SW + MW)'(rem) * (SW + MW)'(RM);
  assign home_full = rem - SW'(quo) * SW'(SLOTS);

  // probe step from i to i+1 adds 2(i+1) - 1 + 23, always below 101
  assign step_sum  = {1'b0, addr} + (SLOT_W + 1)'({i, 1'b0}) + (SLOT_W + 1)'(PROBE_LIN + 1);
  assign addr_next = (step_sum >= (SLOT_W + 1)'(SLOTS)) ?
                     SLOT_W'(step_sum - (SLOT_W + 1)'(SLOTS)) : step_sum[SLOT_W-1:0];
  assign probe_end = (i == PROBE_W'(PROBE_STEPS));

  assign base       = KAW'(addr) * KAW'(MAX_KEY_CHARS);
  assign table_full = cnt >= SLOT_W'(SLOTS);
  assign add_ok     = (func_q == FUNC_ADD) && !table_full && !hit && free_found;
  assign last_idx   = (LW'(j) + LW'(1)) == inc_len;
  assign out_free   = !rv || res_out.ready;

  always_comb begin
    case (state)
      S_CMP, S_COPY: inc_raddr = j + IW'(1);
      default:       inc_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && room) inc_mem[inc_len[IW-1:0]] <= key_in.key_byte;
    inc_q <= inc_mem[inc_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_COPY) key_mem[fbase + KAW'(j)] <= inc_q;
    key_q <= key_mem[pbase + KAW'(inc_raddr)];
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE && add_ok) len_mem[free_slot] <= inc_len;
    len_q <= len_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      inc_len <= '0;
      ovl     <= 1'b0;
      sum     <= '0;
      used    <= '0;
      cnt     <= '0;
      rv      <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (rv && res_out.ready && state != S_FIN) rv <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (room) begin
              inc_len <= len_new;
              sum     <= sum_next;
            end else begin
              ovl <= 1'b1;
            end
            if (key_in.last_byte) begin
              func_q <= key_in.func;
              if (ovl_now) begin
                res_status <= ST_TOO_LONG;
                res_slot   <= '0;
                state      <= S_FIN;
              end else begin
                rem    <= room ? sum_next : sum;
                mod_ph <= 1'b0;
                state  <= S_MOD;
              end
            end
          end
        end
        S_MOD: begin
          if (!mod_ph) begin
            quo    <= prod[SW+MW-1:RS];
            mod_ph <= 1'b1;
          end else begin
            addr  <= home_full[SLOT_W-1:0];   // home slot
            state <= S_PROBE;
          end
          i          <= '0;
          hit        <= 1'b0;
          free_found <= 1'b0;
        end
        S_PROBE: begin
          if (used[addr]) begin
            pbase <= base;
            state <= S_LEN;
          end else begin
            if (!free_found) begin
              free_found <= 1'b1;
              free_slot  <= addr;
              fbase      <= base;
            end
            if (probe_end) begin
              state <= S_DECIDE;
            end else begin
              addr <= addr_next;
              i    <= i + PROBE_W'(1);
            end
          end
        end
        S_LEN: begin
          j <= '0;
          if (len_q == inc_len) begin
            state <= S_CMP;
          end else if (probe_end) begin
            state <= S_DECIDE;
          end else begin
            addr  <= addr_next;
            i     <= i + PROBE_W'(1);
            state <= S_PROBE;
          end
        end
        S_CMP: begin
          if (key_q != inc_q) begin
            if (probe_end) begin
              state <= S_DECIDE;
            end else begin
              addr  <= addr_next;
              i     <= i + PROBE_W'(1);
              state <= S_PROBE;
            end
          end else if (last_idx) begin
            hit      <= 1'b1;
            hit_slot <= addr;
            state    <= S_DECIDE;
          end else begin
            j <= j + IW'(1);
          end
        end
        S_DECIDE: begin
          j     <= '0;
          state <= S_FIN;
          res_slot <= '0;
          if (func_q == FUNC_ADD) begin
            if (table_full) begin
              res_status <= ST_TABLE_FULL;
            end else if (hit) begin
              res_status <= ST_DUPLICATE;
              res_slot   <= hit_slot;
            end else if (free_found) begin
              used[free_slot] <= 1'b1;
              cnt             <= cnt + SLOT_W'(1);
              res_status      <= ST_ADDED;
              res_slot        <= free_slot;
              state           <= S_COPY;
            end else begin
              res_status <= ST_NO_PROBE_SLOT;
            end
          end else begin
            if (hit) begin
              used[hit_slot] <= 1'b0;
              if (cnt != '0) cnt <= cnt - SLOT_W'(1);
              res_status <= ST_REMOVED;
              res_slot   <= hit_slot;
            end else begin
              res_status <= ST_NOT_FOUND;
            end
          end
        end
        S_COPY: begin
          if (last_idx) begin
            state <= S_FIN;
          end else begin
            j <= j + IW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            rv        <= 1'b1;
            ro_status <= res_status;
            ro_slot   <= res_slot;
            ro_held   <= cnt;
            inc_len   <= '0;
            ovl       <= 1'b0;
            sum       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign key_in.ready         = (state == S_IDLE);
  assign res_out.valid        = rv;
  assign res_out.status       = ro_status;
  assign res_out.slot_index   = ro_slot;
  assign res_out.entries_held = ro_held;

  `SKHS_ASSERT_IMP(a_slot_zero, rv && (ro_status == ST_TABLE_FULL || ro_status == ST_NOT_FOUND || ro_status == ST_NO_PROBE_SLOT || ro_status == ST_TOO_LONG), ro_slot == '0, "slot_index must be zero without a slot")
  `SKHS_ASSERT_IMP(a_slot_range, rv, ro_slot < SLOT_W'(SLOTS) && ro_held <= SLOT_W'(SLOTS), "slot or count out of range")
  `SKHS_ASSERT_IMP(a_cnt_step, cnt != $past(cnt), cnt == $past(cnt) + SLOT_W'(1) || cnt + SLOT_W'(1) == $past(cnt), "count moved by more than one")
  `SKHS_ASSERT_NXT(a_busy, key_in.valid && key_in.ready && key_in.last_byte, !key_in.ready, "ready after last byte")

endmodule

// ===== bench/string_key_hash_set_probing_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// String key hash set: testbench
// Streams add and delete keys a byte per beat, tracks the table in a local
// copy of the set and checks status, slot and occupancy of every result.
// ----------------------------------------------------------------------------
module string_key_hash_set_probing_test;
  import skhs_pkg::*;

  localparam int KEY_MAX = DEF_MAX_KEY_CHARS;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic       func;
    logic [7:0] key_byte;
    logic       last_byte;
  } key_beat_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] slot_index;
    logic [6:0] entries_held;
  } set_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skhs_key_if key_in();
  skhs_res_if res_out();

  string_key_hash_set_probing uut (
    .clk(clk),
    .rst(rst),
    .key_in(key_in.sink),
    .res_out(res_out.source)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Local copy of the set, updated per accepted beat.
  logic       tbl_used [SLOTS];
  int         tbl_len [SLOTS];
  logic [7:0] tbl_bytes [SLOTS][KEY_MAX];
  logic [7:0] cur_bytes [KEY_MAX];
  int         cur_len;
  logic       cur_overlong;
  int         cur_sum;
  int         held;

  key_beat_t   beat_q [$];
  set_result_t result_q [$];
  int          errors;
  int          beats_sent;
  int          results_seen;
  int          idle_pct;
  int          stall_pct;
  int          quiet_cycles;
  logic        in_taken;

  // Keys kept for reuse so deletes and duplicates hit live entries.
  logic [7:0] pool [$][$];

  function automatic int probe_of(int home, int i);
    return (home + i * i + PROBE_LIN * i) % SLOTS;
  endfunction

  function automatic bit key_equal(int s);
    if (!tbl_used[s] || tbl_len[s] != cur_len) return 1'b0;
    for (int b = 0; b < cur_len; b++)
      if (tbl_bytes[s][b] != cur_bytes[b]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the set by one beat; returns 1 and the result on a last byte.
  function automatic bit apply_key_beat(key_beat_t kb, output set_result_t r);
    int home;
    int hit;
    int s;
    r = '0;
    if (cur_len < KEY_MAX) begin
      cur_bytes[cur_len] = kb.key_byte;
      cur_len++;
      cur_sum = (cur_sum + HASH_MUL * kb.key_byte * cur_len) % SLOTS;
    end else begin
      cur_overlong = 1'b1;
    end
    if (!kb.last_byte) return 1'b0;
    if (cur_overlong) begin
      r.status = ST_TOO_LONG;
    end else begin
      home = cur_sum;
      hit = SLOTS;
      for (int i = 0; i <= PROBE_STEPS; i++) begin
        s = probe_of(home, i);
        if (key_equal(s)) begin
          hit = s;
          break;
        end
      end
      if (kb.func == FUNC_ADD) begin
        if (held >= SLOTS) begin
          r.status = ST_TABLE_FULL;
        end else if (hit < SLOTS) begin
          r.status = ST_DUPLICATE;
          r.slot_index = hit[6:0];
        end else begin
          r.status = ST_NO_PROBE_SLOT;
          for (int i = 0; i <= PROBE_STEPS; i++) begin
            s = probe_of(home, i);
            if (!tbl_used[s]) begin
              tbl_used[s] = 1'b1;
              tbl_len[s] = cur_len;
              for (int b = 0; b < cur_len; b++) tbl_bytes[s][b] = cur_bytes[b];
              held++;
              r.status = ST_ADDED;
              r.slot_index = s[6:0];
              break;
            end
          end
        end
      end else if (hit < SLOTS) begin
        tbl_used[hit] = 1'b0;
        if (held > 0) held--;
        r.status = ST_REMOVED;
        r.slot_index = hit[6:0];
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    cur_len = 0;
    cur_overlong = 1'b0;
    cur_sum = 0;
    r.entries_held = held[6:0];
    return 1'b1;
  endfunction

  task automatic queue_key(logic f, logic [7:0] k [$]);
    key_beat_t kb;
    for (int i = 0; i < k.size(); i++) begin
      kb.func = (i == k.size() - 1) ? f : logic'($urandom_range(0, 1));
      kb.key_byte = k[i];
      kb.last_byte = (i == k.size() - 1);
      beat_q.push_back(kb);
    end
  endtask

  function automatic void rand_key(int len, output logic [7:0] k [$]);
    k = {};
    for (int i = 0; i < len; i++) k.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Driver: presents the head of the pending queue, idling at random.
  // A presented beat is held until it is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        void'(beat_q.pop_front());
        beats_sent++;
      end
      if (!key_in.valid || in_taken) begin
        if (beat_q.size() > 0 && ($urandom_range(0, 99) >= idle_pct)) begin
          key_in.valid <= 1'b1;
          {key_in.func, key_in.key_byte, key_in.last_byte} <= beat_q[0];
        end else begin
          key_in.valid <= 1'b0;
        end
      end
      res_out.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predicts on accepted key beats, checks accepted results.
  always @(posedge clk) begin
    key_beat_t   kb;
    set_result_t want;
    in_taken <= key_in.valid && key_in.ready;
    if (!rst) begin
      if ((key_in.valid && key_in.ready) || (res_out.valid && res_out.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (key_in.valid && key_in.ready) begin
        kb = {key_in.func, key_in.key_byte, key_in.last_byte};
        if (apply_key_beat(kb, want)) result_q.push_back(want);
      end
      if (res_out.valid && res_out.ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("result with none expected: status %0d", res_out.status);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (res_out.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_out.status);
            errors++;
          end
          if (res_out.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index,
                   res_out.slot_index);
            errors++;
          end
          if (res_out.entries_held !== want.entries_held) begin
            $error("entries_held: expected %0d, got %0d", want.entries_held,
                   res_out.entries_held);
            errors++;
          end
        end
      end
    end
  end

  task automatic drain;
    while (beat_q.size() > 0 || result_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] k [$];
    int         pick;
    int         len;
    errors = 0;
    beats_sent = 0;
    results_seen = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    held = 0;
    cur_len = 0;
    cur_sum = 0;
    cur_overlong = 1'b0;
    for (int s = 0; s < SLOTS; s++) tbl_used[s] = 1'b0;
    key_in.valid = 1'b0;
    key_in.func = FUNC_ADD;
    key_in.key_byte = '0;
    key_in.last_byte = 1'b0;
    res_out.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, both commands, duplicate, not found,
    // single-byte and maximum-length keys, overlong key.
    k = {8'h00};                 queue_key(FUNC_ADD, k);
    k = {8'hff};                 queue_key(FUNC_ADD, k);
    k = {8'hff};                 queue_key(FUNC_ADD, k);
    k = {8'h00};                 queue_key(FUNC_DEL, k);
    k = {8'h00};                 queue_key(FUNC_DEL, k);
    k = {8'h55, 8'haa};          queue_key(FUNC_DEL, k);
    rand_key(KEY_MAX, k);        queue_key(FUNC_ADD, k); pool.push_back(k);
    queue_key(FUNC_ADD, k);
    queue_key(FUNC_DEL, k);
    rand_key(KEY_MAX + 3, k);    queue_key(FUNC_ADD, k);
    k = {8'h01, 8'h02};          queue_key(FUNC_ADD, k);
    k = {8'h02, 8'h01};          queue_key(FUNC_ADD, k);
    drain();

    // Random: half the commands reuse a pooled key to hit duplicates and deletes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < 12; n++) begin
        pick = $urandom_range(0, 9);
        if (pool.size() > 0 && pick < 5) begin
          k = pool[$urandom_range(0, pool.size() - 1)];
          queue_key(logic'(pick < 2), k);
        end else if (pick == 9) begin
          rand_key($urandom_range(KEY_MAX + 1, KEY_MAX + 4), k);
          queue_key(logic'($urandom_range(0, 1)), k);
        end else begin
          len = ($urandom_range(0, 7) == 0) ? KEY_MAX : $urandom_range(1, 3);
          rand_key(len, k);
          queue_key(FUNC_ADD, k);
          if (pool.size() < 40) pool.push_back(k);
        end
      end
      drain();
    end

    // Add 130 single-byte keys to drive the set toward no probe slot or full.
    idle_pct = 0;
    stall_pct = 0;
    for (int n = 0; n < 130; n++) begin
      k = {8'(n)};
      queue_key(FUNC_ADD, k);
    end
    drain();
    repeat (200) @(posedge clk);

    $display("Sent %0d key beats, checked %0d results, final occupancy %0d.",
             beats_sent, results_seen, held);
    if (errors == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (quiet_cycles > WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/skhs_pkg.sv
hdl/skhs_key_if.sv
hdl/skhs_res_if.sv
hdl/string_key_hash_set_probing.sv
bench/string_key_hash_set_probing_test.sv
